/* rtl/fir_filter_decimate_interpolate_top_macros.svh */
// ----------------------------------------------------------------------------
// fir engine assertion macros
// shared property wrappers, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_DECIMATE_INTERPOLATE_TOP_MACROS_SVH
`define FIR_FILTER_DECIMATE_INTERPOLATE_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define FDI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// expression holds at every clock edge out of reset
`define FDI_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

/* rtl/fdi_pkg.sv */
// ----------------------------------------------------------------------------
// fdi_pkg
// shared types and codes of the polyphase fir engine
// ----------------------------------------------------------------------------
`default_nettype none

package fdi_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int OP_W        = 2;
    localparam int CIDX_W      = 10;
    localparam int MODE_W      = 2;
    localparam int TAPS_REG_W  = 7;
    localparam int FACT_REG_W  = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_VALUE_W = 7;

    // request opcodes
    localparam logic [OP_W-1:0] OP_PROCESS = 2'd0;
    localparam logic [OP_W-1:0] OP_COEF    = 2'd1;
    localparam logic [OP_W-1:0] OP_PUSH    = 2'd2;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_FILTER   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DECIMATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INTERP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DELAY    = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAPS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR = 2'd2;

    localparam logic [TAPS_REG_W-1:0] TAPS_RESET   = 7'd64;
    localparam logic [FACT_REG_W-1:0] FACTOR_RESET = 5'd1;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic signed [SAMPLE_W-1:0] sample;
        logic [CIDX_W-1:0]          coef_index;
        logic signed [COEF_W-1:0]   coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } out_item_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_VALUE_W-1:0] value;
    } cfg_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic coef_wr;
        logic push_in;
        logic latch;
        logic push_held;
        logic phase_step;
        logic first_phase;
        logic next_phase;
        logic issue;
        logic stride_one;
        logic delay_rd;
        logic load_mac;
        logic load_delay;
        logic out_last;
    } fdi_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic pipe_busy;
        logic last_tap;
        logic last_phase;
        logic phase_zero;
        logic out_free;
    } fdi_status_t;

endpackage

`default_nettype wire

/* rtl/fdi_stream_if.sv */
// ----------------------------------------------------------------------------
// fdi_stream_if
// valid/ready channel carrying one payload of a given type
// ----------------------------------------------------------------------------
`default_nettype none

interface fdi_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/fir_filter_decimate_interpolate_top.sv */
// ----------------------------------------------------------------------------
// fir_filter_decimate_interpolate_top
// polyphase fir engine: filter, decimator, interpolator or delay line
//
// channel   dir   payload                               notes
// item      in    op, sample, coef_index, coef_value    one request per item
// result    out   value, last                           up to factor per item
// cfg       in    index, value                          mode, tap_count, factor
//
// coefficient write, push and ignored ops are handled in the idle state
// filter or decimate with result: single mac over tap_count taps, drain, load
// interpolate: mac, drain, load per phase, push; delay line: read, load, push
// decimate without result: the held sample is pushed, with no mac pass
// no clearing pass after reset: a history fill count masks unwritten taps
// a waiting result holds only the result register; new items are accepted
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_decimate_interpolate_top #(
    parameter int MAX_TAPS   = 64,
    parameter int MAX_FACTOR = 16,
    parameter int COEF_DEPTH = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    fdi_stream_if.sink    item,
    fdi_stream_if.source  result,
    fdi_stream_if.sink    cfg
);
    import fdi_pkg::*;

    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int FW = $clog2(MAX_FACTOR + 1);

    logic [MODE_W-1:0] mode;
    logic [TW-1:0]     taps;
    logic [FW-1:0]     factor;
    logic              in_ready;
    fdi_cmd_t          cmd;
    fdi_status_t       status;
    in_item_t          in_item;
    cfg_item_t         cfg_item;
    out_item_t         out_item;
    logic              out_valid;

    assign in_item    = item.data;
    assign cfg_item   = cfg.data;
    assign item.ready = in_ready;

    // configuration registers
    fdi_cfg_regs #(
        .MAX_TAPS   (MAX_TAPS),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_item  (cfg_item),
        .mode      (mode),
        .taps      (taps),
        .factor    (factor)
    );

    // sequencer
    fdi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode),
        .in_valid (item.valid),
        .in_op    (in_item.op),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath
    fdi_datapath #(
        .MAX_TAPS   (MAX_TAPS),
        .MAX_FACTOR (MAX_FACTOR),
        .COEF_DEPTH (COEF_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .taps      (taps),
        .factor    (factor),
        .in_item   (in_item),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_ready (result.ready)
    );

    assign result.valid = out_valid;
    assign result.data  = out_item;

endmodule

`default_nettype wire

/* rtl/fdi_cfg_regs.sv */
// ----------------------------------------------------------------------------
// fdi_cfg_regs
// configuration registers with range clamping of taps and factor
// ----------------------------------------------------------------------------
`default_nettype none

module fdi_cfg_regs #(
    parameter int MAX_TAPS   = 64,
    parameter int MAX_FACTOR = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  fdi_pkg::cfg_item_t        cfg_item,
    output logic [fdi_pkg::MODE_W-1:0] mode,
    output logic [$clog2(MAX_TAPS+1)-1:0]   taps,
    output logic [$clog2(MAX_FACTOR+1)-1:0] factor
);
    import fdi_pkg::*;

    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int FW = $clog2(MAX_FACTOR + 1);

    logic [MODE_W-1:0]     mode_reg,   mode_next;
    logic [TAPS_REG_W-1:0] taps_reg,   taps_next;
    logic [FACT_REG_W-1:0] factor_reg, factor_next;

    assign cfg_ready = 1'b1;

    // register write decode, unknown indexes ignored
    always_comb
    begin
        mode_next   = mode_reg;
        taps_next   = taps_reg;
        factor_next = factor_reg;
        if (cfg_valid)
        begin
            case (cfg_item.index)
                CFG_MODE:   mode_next   = cfg_item.value[MODE_W-1:0];
                CFG_TAPS:   taps_next   = cfg_item.value[TAPS_REG_W-1:0];
                CFG_FACTOR: factor_next = cfg_item.value[FACT_REG_W-1:0];
                default:    mode_next   = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_FILTER;
            taps_reg   <= TAPS_RESET;
            factor_reg <= FACTOR_RESET;
        end
        else
        begin
            mode_reg   <= mode_next;
            taps_reg   <= taps_next;
            factor_reg <= factor_next;
        end
    end

    // effective values, clamped to 1..max
    always_comb
    begin
        mode = mode_reg;
        if (taps_reg == '0)
            taps = TW'(1);
        else if (32'(taps_reg) > MAX_TAPS)
            taps = TW'(MAX_TAPS);
        else
            taps = TW'(taps_reg);

        if (factor_reg == '0)
            factor = FW'(1);
        else if (32'(factor_reg) > MAX_FACTOR)
            factor = FW'(MAX_FACTOR);
        else
            factor = FW'(factor_reg);
    end

endmodule

`default_nettype wire

/* rtl/fdi_ctrl.sv */
// ----------------------------------------------------------------------------
// fdi_ctrl
// sequencer: decodes requests and steps the shared multiply-accumulate
// ----------------------------------------------------------------------------
`default_nettype none

module fdi_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fdi_pkg::MODE_W-1:0]  mode,
    input  logic                        in_valid,
    input  logic [fdi_pkg::OP_W-1:0]    in_op,
    output logic                        in_ready,
    output fdi_pkg::fdi_cmd_t           cmd,
    input  fdi_pkg::fdi_status_t        status
);
    import fdi_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_MAC      = 7'b0000010,
        S_DRAIN    = 7'b0000100,
        S_LOAD     = 7'b0001000,
        S_DLY_RD   = 7'b0010000,
        S_DLY_LOAD = 7'b0100000,
        S_PUSH     = 7'b1000000
    } fdi_state_t;

    fdi_state_t state_reg, state_next;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_op)
                        OP_COEF: cmd.coef_wr = 1'b1;
                        OP_PUSH: cmd.push_in = 1'b1;
                        OP_PROCESS:
                        begin
                            cmd.latch = 1'b1;
                            if (mode == MODE_DELAY)
                                state_next = S_DLY_RD;
                            else if (mode == MODE_DECIMATE && !status.phase_zero)
                                state_next = S_PUSH;
                            else if (mode inside {MODE_FILTER, MODE_DECIMATE, MODE_INTERP})
                            begin
                                cmd.first_phase = 1'b1;
                                state_next      = S_MAC;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_MAC:
            begin
                // coefficient stride is the factor only when interpolating
                cmd.issue      = 1'b1;
                cmd.stride_one = (mode != MODE_INTERP);
                if (status.last_tap)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_mac = 1'b1;
                    cmd.out_last = (mode != MODE_INTERP) || status.last_phase;
                    if (!cmd.out_last)
                    begin
                        cmd.next_phase = 1'b1;
                        state_next     = S_MAC;
                    end
                    else
                        state_next = S_PUSH;
                end
            end
            S_DLY_RD:
            begin
                cmd.delay_rd = 1'b1;
                state_next   = S_DLY_LOAD;
            end
            S_DLY_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_delay = 1'b1;
                    cmd.out_last   = 1'b1;
                    state_next     = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push_held  = 1'b1;
                cmd.phase_step = (mode == MODE_DECIMATE);
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* rtl/fdi_datapath.sv */
// ----------------------------------------------------------------------------
// fdi_datapath
// history ring, coefficient store, mac pipeline and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "fir_filter_decimate_interpolate_top_macros.svh"

module fdi_datapath #(
    parameter int MAX_TAPS   = 64,
    parameter int MAX_FACTOR = 16,
    parameter int COEF_DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fdi_pkg::fdi_cmd_t               cmd,
    output fdi_pkg::fdi_status_t            status,
    input  logic [$clog2(MAX_TAPS+1)-1:0]   taps,
    input  logic [$clog2(MAX_FACTOR+1)-1:0] factor,
    input  fdi_pkg::in_item_t               in_item,
    output fdi_pkg::out_item_t              out_item,
    output logic                            out_valid,
    input  logic                            out_ready
);
    import fdi_pkg::*;

    localparam int TW    = $clog2(MAX_TAPS + 1);
    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int HP_W  = $clog2(MAX_TAPS);
    localparam int CA_W  = $clog2(COEF_DEPTH);
    localparam int AW    = $clog2(MAX_FACTOR * (MAX_TAPS + 1));
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
    localparam int FRAC_W = 15;

    localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(16384);
    localparam logic signed [ACC_W:0] SAT_HI   = (ACC_W+1)'(32767);
    localparam logic signed [ACC_W:0] SAT_LO   = (ACC_W+1)'(-32768);

    // storage
    logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];

    // control state
    logic [HP_W-1:0] head_reg,   head_next;
    logic [TW-1:0]   fill_reg,   fill_next;
    logic [FW-1:0]   phase_reg,  phase_next;
    logic            s1_valid_reg, s1_valid_next;
    logic            s2_valid_reg, s2_valid_next;
    logic            out_valid_reg, out_valid_next;

    // payload state
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [HP_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [HP_W-1:0]            j_reg,      j_next;
    logic [AW-1:0]              caddr_reg,  caddr_next;
    logic [FW-1:0]              base_reg,   base_next;
    logic                       hok_reg,    hok_next;
    logic                       cok_reg,    cok_next;
    logic                       dly_ok_reg, dly_ok_next;
    logic signed [PROD_W-1:0]   prod_reg,   prod_next;
    logic signed [ACC_W-1:0]    acc_reg,    acc_next;
    logic signed [SAMPLE_W-1:0] outv_reg,   outv_next;
    logic                       outl_reg,   outl_next;
    logic signed [SAMPLE_W-1:0] hist_q;
    logic signed [COEF_W-1:0]   coef_q;

    logic                       push_en;
    logic signed [SAMPLE_W-1:0] push_data;
    logic [HP_W-1:0]            hist_raddr;
    logic [HP_W-1:0]            head_prev;
    logic [TW:0]                head_x;
    logic [TW:0]                dly_addr_x;
    logic [FW:0]                phase_inc;
    logic signed [SAMPLE_W-1:0] h1;
    logic signed [COEF_W-1:0]   c1;
    logic signed [ACC_W:0]      rnd;
    logic signed [ACC_W:0]      rnd_q;
    logic signed [SAMPLE_W-1:0] mac_value;

    assign push_en   = cmd.push_in || cmd.push_held;
    assign push_data = cmd.push_in ? in_item.sample : sample_reg;
    assign head_prev = (head_reg == '0) ? HP_W'(MAX_TAPS - 1) : head_reg - HP_W'(1);

    // sample from tap_count items back: head minus taps, modulo depth
    assign head_x     = (TW+1)'(head_reg);
    assign dly_addr_x = (head_x >= (TW+1)'(taps)) ? head_x - (TW+1)'(taps)
                                                  : head_x + (TW+1)'(MAX_TAPS) - (TW+1)'(taps);
    assign hist_raddr = cmd.delay_rd ? dly_addr_x[HP_W-1:0] : rd_ptr_reg;

    // zero taps not yet filled and coefficients beyond the store
    assign h1 = hok_reg ? hist_q : '0;
    assign c1 = cok_reg ? coef_q : '0;

    // round half up to q15 and saturate
    assign rnd   = (ACC_W+1)'(acc_reg) + RND_HALF;
    assign rnd_q = rnd >>> FRAC_W;
    always_comb
    begin
        if (rnd_q > SAT_HI)
            mac_value = 16'sh7fff;
        else if (rnd_q < SAT_LO)
            mac_value = 16'sh8000;
        else
            mac_value = rnd_q[SAMPLE_W-1:0];
    end

    assign phase_inc = (FW+1)'(phase_reg) + (FW+1)'(1);

    // next values
    always_comb
    begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        sample_next    = sample_reg;
        rd_ptr_next    = rd_ptr_reg;
        j_next         = j_reg;
        caddr_next     = caddr_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        outv_next      = outv_reg;
        outl_next      = outl_reg;
        dly_ok_next    = dly_ok_reg;
        out_valid_next = out_valid_reg;

        // history ring advance
        if (push_en)
        begin
            head_next = (head_reg == HP_W'(MAX_TAPS - 1)) ? '0 : head_reg + HP_W'(1);
            if (fill_reg != TW'(MAX_TAPS))
                fill_next = fill_reg + TW'(1);
        end

        // decimation phase, wraps when reaching the factor
        if (cmd.phase_step)
            phase_next = (phase_inc >= (FW+1)'(factor)) ? '0 : phase_inc[FW-1:0];

        if (cmd.latch)
            sample_next = in_item.sample;

        // start of one result
        if (cmd.first_phase)
        begin
            base_next   = '0;
            caddr_next  = '0;
            j_next      = '0;
            rd_ptr_next = head_prev;
            acc_next    = '0;
        end
        else if (cmd.next_phase)
        begin
            base_next   = base_reg + FW'(1);
            caddr_next  = AW'(base_reg) + AW'(1);
            j_next      = '0;
            rd_ptr_next = head_prev;
            acc_next    = '0;
        end
        else if (s2_valid_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);

        // tap address step, coefficient stride one or the factor
        if (cmd.issue)
        begin
            j_next      = j_reg + HP_W'(1);
            caddr_next  = cmd.stride_one ? caddr_reg + AW'(1) : caddr_reg + AW'(factor);
            rd_ptr_next = (rd_ptr_reg == '0) ? HP_W'(MAX_TAPS - 1) : rd_ptr_reg - HP_W'(1);
        end

        if (cmd.delay_rd)
            dly_ok_next = (fill_reg >= taps);

        // result register
        if (cmd.load_mac)
        begin
            outv_next      = mac_value;
            outl_next      = cmd.out_last;
            out_valid_next = 1'b1;
        end
        else if (cmd.load_delay)
        begin
            outv_next      = dly_ok_reg ? hist_q : '0;
            outl_next      = cmd.out_last;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // mac pipeline stage flags and operands
    assign s1_valid_next = cmd.issue;
    assign s2_valid_next = s1_valid_reg;
    assign hok_next      = (TW'(j_reg) < fill_reg);
    assign cok_next      = (32'(caddr_reg) < COEF_DEPTH);
    assign prod_next     = h1 * c1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            phase_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        rd_ptr_reg <= rd_ptr_next;
        j_reg      <= j_next;
        caddr_reg  <= caddr_next;
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        outv_reg   <= outv_next;
        outl_reg   <= outl_next;
        dly_ok_reg <= dly_ok_next;
        prod_reg   <= prod_next;
        if (cmd.issue)
        begin
            hok_reg <= hok_next;
            cok_reg <= cok_next;
        end
    end

    // history memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (push_en)
            hist_mem[head_reg] <= push_data;
        if (cmd.issue || cmd.delay_rd)
            hist_q <= hist_mem[hist_raddr];
    end

    // coefficient memory, writes beyond the depth dropped
    always_ff @(posedge clk)
    begin
        if (cmd.coef_wr && (32'(in_item.coef_index) < COEF_DEPTH))
            coef_mem[CA_W'(in_item.coef_index)] <= in_item.coef_value;
        if (cmd.issue)
            coef_q <= coef_mem[CA_W'(caddr_reg)];
    end

    // status back to the sequencer
    assign status.pipe_busy  = s1_valid_reg || s2_valid_reg;
    assign status.last_tap   = (TW'(j_reg) == taps - TW'(1));
    assign status.last_phase = (base_reg == factor - FW'(1));
    assign status.phase_zero = (phase_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_item.value = outv_reg;
    assign out_item.last  = outl_reg;

    // checks
    `FDI_ASSERT_IMPL(a_load_after_drain, cmd.load_mac, !status.pipe_busy, "load before drain")
    `FDI_ASSERT_IMPL(a_no_overwrite, cmd.load_mac || cmd.load_delay, status.out_free, "result lost")
    `FDI_ASSERT_ALWAYS(a_fill_bound, fill_reg <= TW'(MAX_TAPS), "fill count past depth")

endmodule

`default_nettype wire
